FILE: hw/rtl/direction_map_hole_fill_defines.svh
// Assertion macros shared by the direction map hole fill checker.
`ifndef DIRECTION_MAP_HOLE_FILL_DEFINES_SVH
`define DIRECTION_MAP_HOLE_FILL_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define DMHF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DMHF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/dmhf_pkg.sv
// Types, codes and helper functions for the direction map hole fill block.
`timescale 1ns / 1ps
package dmhf_pkg;

   localparam int DMHF_MAX_WIDTH  = 256;
   localparam int DMHF_MAX_HEIGHT = 256;

   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_RUN  = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_PASSES = 2'd2;

   localparam int          CSR_DATA_W   = 9;
   localparam logic [8:0]  RST_WIDTH    = 9'd256;
   localparam logic [8:0]  RST_HEIGHT   = 9'd256;
   localparam logic [3:0]  RST_PASSES   = 4'd4;
   localparam logic [3:0]  LAST_TAP     = 4'd8;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] pixel_x;
      logic [7:0] pixel_y;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
   } dmhf_req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
   } dmhf_rsp_type;

   typedef struct packed {
      logic       load_wr;
      logic       req_rd;
      logic       tap_rd;
      logic [3:0] tap_idx;
      logic       div_go;
      logic       next_wr;
      logic       copy_rd;
      logic       copy_wr;
      logic       fin_rd;
      logic       fin_wr;
      logic       pix_clr;
      logic       pix_step;
   } dmhf_cmd_type;

   typedef struct packed {
      logic       last_pix;
      logic [3:0] passes;
   } dmhf_status_type;

   // Tap 0 is the centre pixel, taps 1 to 8 walk round its neighbours.
   function automatic logic signed [1:0] tap_dx(input logic [3:0] idx);
      logic signed [1:0] d;
      case (idx)
         4'd2, 4'd3, 4'd4: d = 2'sd1;
         4'd6, 4'd7, 4'd8: d = -2'sd1;
         default:          d = 2'sd0;
      endcase
      return d;
   endfunction

   function automatic logic signed [1:0] tap_dy(input logic [3:0] idx);
      logic signed [1:0] d;
      case (idx)
         4'd1, 4'd2, 4'd8: d = 2'sd1;
         4'd4, 4'd5, 4'd6: d = -2'sd1;
         default:          d = 2'sd0;
      endcase
      return d;
   endfunction

   // Rounded-up 2^16 / c; exact floor quotient for sums below 2048.
   function automatic logic [16:0] recip(input logic [3:0] c);
      logic [16:0] r;
      case (c)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd5:    r = 17'd13108;
         4'd6:    r = 17'd10923;
         4'd7:    r = 17'd9363;
         4'd8:    r = 17'd8192;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/dmhf_ctrl.sv
// Sequencer for requests and the fill, copy and final sweeps.
`timescale 1ns / 1ps
module dmhf_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [1:0]                req_type,
   input  dmhf_pkg::dmhf_status_type status,
   output logic                      busy,
   output logic                      rsp_valid,
   output dmhf_pkg::dmhf_cmd_type    cmd
);
   import dmhf_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_TAP  = 4'd1;
   localparam logic [3:0] S_LAST = 4'd2;
   localparam logic [3:0] S_DIV  = 4'd3;
   localparam logic [3:0] S_WR   = 4'd4;
   localparam logic [3:0] S_CRD  = 4'd5;
   localparam logic [3:0] S_CWR  = 4'd6;
   localparam logic [3:0] S_FRD  = 4'd7;
   localparam logic [3:0] S_FWR  = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] tap_ff;
   logic [3:0] pass_ff;
   logic       resp_ff;
   logic       accept;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = resp_ff || (state_ff == S_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tap_ff   <= '0;
         pass_ff  <= '0;
         resp_ff  <= 1'b0;
      end else begin
         resp_ff <= accept && (req_type != REQ_RUN);
         case (state_ff)
            S_IDLE: begin
               tap_ff  <= '0;
               pass_ff <= '0;
               if (accept && req_type == REQ_RUN) begin
                  state_ff <= (status.passes != 4'd0) ? S_TAP : S_FRD;
               end
            end
            S_TAP: begin
               if (tap_ff == LAST_TAP) begin
                  tap_ff   <= '0;
                  state_ff <= S_LAST;
               end else begin
                  tap_ff <= tap_ff + 4'd1;
               end
            end
            S_LAST: state_ff <= S_DIV;
            S_DIV:  state_ff <= S_WR;
            S_WR:   state_ff <= status.last_pix ? S_CRD : S_TAP;
            S_CRD:  state_ff <= S_CWR;
            S_CWR: begin
               if (status.last_pix) begin
                  pass_ff  <= pass_ff + 4'd1;
                  state_ff <= (pass_ff + 4'd1 == status.passes) ? S_FRD : S_TAP;
               end else begin
                  state_ff <= S_CRD;
               end
            end
            S_FRD:  state_ff <= S_FWR;
            S_FWR:  state_ff <= status.last_pix ? S_DONE : S_FRD;
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.load_wr  = accept && (req_type == REQ_LOAD);
      cmd.req_rd   = accept && (req_type == REQ_READ);
      cmd.tap_rd   = (state_ff == S_TAP);
      cmd.tap_idx  = tap_ff;
      cmd.div_go   = (state_ff == S_DIV);
      cmd.next_wr  = (state_ff == S_WR);
      cmd.copy_rd  = (state_ff == S_CRD);
      cmd.copy_wr  = (state_ff == S_CWR);
      cmd.fin_rd   = (state_ff == S_FRD);
      cmd.fin_wr   = (state_ff == S_FWR);
      cmd.pix_clr  = (state_ff == S_IDLE);
      cmd.pix_step = (state_ff == S_WR) || (state_ff == S_CWR) || (state_ff == S_FWR);
   end

endmodule

FILE: hw/rtl/dmhf_datapath.sv
// Image stores, scan counters, neighbour accumulation and reciprocal divide.
`timescale 1ns / 1ps
module dmhf_datapath #(
   parameter int MAX_WIDTH  = dmhf_pkg::DMHF_MAX_WIDTH,
   parameter int MAX_HEIGHT = dmhf_pkg::DMHF_MAX_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dmhf_pkg::dmhf_req_type    req_data,
   input  dmhf_pkg::dmhf_cmd_type    cmd,
   input  logic                      csr_valid,
   input  logic [1:0]                csr_index,
   input  logic [8:0]                csr_wdata,
   output dmhf_pkg::dmhf_status_type status,
   output dmhf_pkg::dmhf_rsp_type    rsp_data
);
   import dmhf_pkg::*;

   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int DWW   = (WW > CSR_DATA_W) ? WW : CSR_DATA_W;
   localparam int DHW   = (HW > CSR_DATA_W) ? HW : CSR_DATA_W;

   logic [31:0] cur_mem [DEPTH];
   logic [31:0] nxt_mem [DEPTH];

   logic [8:0]  width_ff;
   logic [8:0]  height_ff;
   logic [3:0]  passes_ff;
   logic [WW-1:0] x_ff;
   logic [HW-1:0] y_ff;
   logic [31:0] cur_q_ff;
   logic [31:0] nxt_q_ff;
   logic        show_ff;
   logic        pend_ff;
   logic        vld_ff;
   logic [3:0]  ptap_ff;
   logic [31:0] center_ff;
   logic [10:0] acc_r_ff, acc_g_ff, acc_b_ff;
   logic [3:0]  cnt_ff;
   logic [27:0] prod_r_ff, prod_g_ff, prod_b_ff;

   logic [DWW-1:0] w_wide;
   logic [DHW-1:0] h_wide;
   logic [WW-1:0]  w_eff;
   logic [HW-1:0]  h_eff;
   logic           last_x, last_y;
   logic signed [1:0] dx, dy;
   logic [WW-1:0]  nx;
   logic [HW-1:0]  ny;
   logic           tap_ok;
   logic [AW-1:0]  pix_addr, tap_addr, req_addr, rd_addr, wr_addr;
   logic           in_image;
   logic           cur_we;
   logic [31:0]    cur_wd;
   logic [31:0]    fill_pix;
   logic [16:0]    rcp;

   always_comb begin
      w_wide = DWW'(width_ff);
      if (w_wide == '0) begin
         w_wide = DWW'(1);
      end else if (w_wide > DWW'(MAX_WIDTH)) begin
         w_wide = DWW'(MAX_WIDTH);
      end
      h_wide = DHW'(height_ff);
      if (h_wide == '0) begin
         h_wide = DHW'(1);
      end else if (h_wide > DHW'(MAX_HEIGHT)) begin
         h_wide = DHW'(MAX_HEIGHT);
      end
   end
   assign w_eff = WW'(w_wide);
   assign h_eff = HW'(h_wide);

   assign last_x = (x_ff == w_eff - WW'(1));
   assign last_y = (y_ff == h_eff - HW'(1));
   assign status.last_pix = last_x && last_y;
   assign status.passes   = passes_ff;

   assign dx = tap_dx(cmd.tap_idx);
   assign dy = tap_dy(cmd.tap_idx);
   assign nx = x_ff + WW'(dx);
   assign ny = y_ff + HW'(dy);
   assign tap_ok = !(dx == -2'sd1 && x_ff == '0) && !(dx == 2'sd1 && last_x)
                && !(dy == -2'sd1 && y_ff == '0) && !(dy == 2'sd1 && last_y);

   assign pix_addr = AW'(AW'(y_ff) * AW'(MAX_WIDTH) + AW'(x_ff));
   assign tap_addr = AW'(AW'(ny) * AW'(MAX_WIDTH) + AW'(nx));
   assign req_addr = AW'(AW'(req_data.pixel_y) * AW'(MAX_WIDTH) + AW'(req_data.pixel_x));
   assign in_image = (DWW'(req_data.pixel_x) < w_wide) && (DHW'(req_data.pixel_y) < h_wide);
   assign rd_addr  = cmd.tap_rd ? tap_addr : (cmd.fin_rd ? pix_addr : req_addr);

   always_comb begin
      cur_we  = 1'b0;
      cur_wd  = nxt_q_ff;
      wr_addr = pix_addr;
      if (cmd.load_wr) begin
         cur_we  = in_image;
         wr_addr = req_addr;
         cur_wd  = {req_data.in_alpha, req_data.in_blue, req_data.in_green, req_data.in_red};
      end else if (cmd.copy_wr) begin
         cur_we = 1'b1;
      end else if (cmd.fin_wr) begin
         cur_we = (cur_q_ff[23:16] == 8'd0);
         cur_wd = {cur_q_ff[31:24], 8'hFF, 16'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[wr_addr] <= cur_wd;
      end
      cur_q_ff <= cur_mem[rd_addr];
   end

   // A hole with no valid neighbour keeps its value.
   always_comb begin
      if (center_ff[23:16] != 8'd0 || cnt_ff == 4'd0) begin
         fill_pix = center_ff;
      end else begin
         fill_pix = {center_ff[31:24], prod_b_ff[23:16], prod_g_ff[23:16], prod_r_ff[23:16]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.next_wr) begin
         nxt_mem[pix_addr] <= fill_pix;
      end
      if (cmd.copy_rd) begin
         nxt_q_ff <= nxt_mem[pix_addr];
      end
   end

   assign rcp = recip(cnt_ff);

   always_ff @(posedge clock) begin
      if (cmd.div_go) begin
         prod_r_ff <= 28'(acc_r_ff) * 28'(rcp);
         prod_g_ff <= 28'(acc_g_ff) * 28'(rcp);
         prod_b_ff <= 28'(acc_b_ff) * 28'(rcp);
      end
      if (pend_ff && ptap_ff == 4'd0) begin
         center_ff <= cur_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
         passes_ff <= RST_PASSES;
         x_ff      <= '0;
         y_ff      <= '0;
         show_ff   <= 1'b0;
         pend_ff   <= 1'b0;
         vld_ff    <= 1'b0;
         ptap_ff   <= '0;
         acc_r_ff  <= '0;
         acc_g_ff  <= '0;
         acc_b_ff  <= '0;
         cnt_ff    <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_WIDTH:  width_ff  <= csr_wdata;
               CSR_HEIGHT: height_ff <= csr_wdata;
               CSR_PASSES: passes_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
         show_ff <= cmd.req_rd && in_image;
         pend_ff <= cmd.tap_rd;
         vld_ff  <= cmd.tap_rd && tap_ok;
         ptap_ff <= cmd.tap_idx;
         if (cmd.pix_clr) begin
            x_ff <= '0;
            y_ff <= '0;
         end else if (cmd.pix_step) begin
            if (last_x) begin
               x_ff <= '0;
               y_ff <= last_y ? '0 : y_ff + HW'(1);
            end else begin
               x_ff <= x_ff + WW'(1);
            end
         end
         if (cmd.tap_rd && cmd.tap_idx == 4'd0) begin
            acc_r_ff <= '0;
            acc_g_ff <= '0;
            acc_b_ff <= '0;
            cnt_ff   <= '0;
         end else if (pend_ff && ptap_ff != 4'd0 && vld_ff && cur_q_ff[23:16] != 8'd0) begin
            acc_r_ff <= acc_r_ff + 11'(cur_q_ff[7:0]);
            acc_g_ff <= acc_g_ff + 11'(cur_q_ff[15:8]);
            acc_b_ff <= acc_b_ff + 11'(cur_q_ff[23:16]);
            cnt_ff   <= cnt_ff + 4'd1;
         end
      end
   end

   assign rsp_data.out_red   = show_ff ? cur_q_ff[7:0]   : 8'd0;
   assign rsp_data.out_green = show_ff ? cur_q_ff[15:8]  : 8'd0;
   assign rsp_data.out_blue  = show_ff ? cur_q_ff[23:16] : 8'd0;
   assign rsp_data.out_alpha = show_ff ? cur_q_ff[31:24] : 8'd0;

endmodule

FILE: hw/rtl/direction_map_hole_fill.sv
// Top level of the direction map hole fill block.
//
//  Channel  Ports                               Transfer
//  request  start, busy, req_data               start high and busy low
//  result   rsp_valid, rsp_data                 one-cycle strobe, cannot be held off
//  control  csr_valid, csr_ready, csr_index,    csr_valid and csr_ready high
//           csr_wdata
//
// A load or read transfer may be followed at once by the next; its
// result strobes in the cycle after the transfer, with zeros for a load.
// A run keeps busy high until its final sweep is done: every pass makes
// nine reads of the current image per pixel on its single read port, then
// divides and stores the pixel in S_LAST, S_DIV and S_WR, then copies the
// pass back pixel by pixel; the final sweep reads and writes each pixel. The run's
// result strobes in the last busy cycle.
// Reset is synchronous and restores the register defaults; the image stores
// hold no reset value. The receiver cannot stall, so results are never held.
`timescale 1ns / 1ps
module direction_map_hole_fill #(
   parameter int MAX_WIDTH  = dmhf_pkg::DMHF_MAX_WIDTH,
   parameter int MAX_HEIGHT = dmhf_pkg::DMHF_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  dmhf_pkg::dmhf_req_type req_data,
   output logic                   rsp_valid,
   output dmhf_pkg::dmhf_rsp_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [8:0]             csr_wdata
);
   import dmhf_pkg::*;

   dmhf_cmd_type    cmd;
   dmhf_status_type status;

   // The user must make register writes only while idle; nothing enforces it.
   assign csr_ready = 1'b1;

   // The sequencer decides when each sweep reads and writes.
   dmhf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_data.req_type),
      .status    (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // The datapath holds both image stores and the neighbour arithmetic.
   dmhf_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hw/rtl/dmhf_checker.sv
// Port-level checks for the direction map hole fill block, bound to its top.
`timescale 1ns / 1ps
`include "direction_map_hole_fill_defines.svh"
module dmhf_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input dmhf_pkg::dmhf_req_type req_data,
   input logic                   rsp_valid,
   input dmhf_pkg::dmhf_rsp_type rsp_data
);
   import dmhf_pkg::*;

   `DMHF_ASSERT_NEXT(a_quick_rsp, clock, reset, start && !busy && req_data.req_type != REQ_RUN, rsp_valid, "load or read without a result in the next cycle")
   `DMHF_ASSERT_NEXT(a_run_busy, clock, reset, start && !busy && req_data.req_type == REQ_RUN, busy, "run transfer did not raise busy")
   `DMHF_ASSERT_NEXT(a_load_zero, clock, reset, start && !busy && req_data.req_type == REQ_LOAD, rsp_data == '0, "load result not zero")
   `DMHF_ASSERT_SAME(a_run_end, clock, reset, $fell(busy) && !$past(reset), $past(rsp_valid), "run ended without a result")

endmodule

bind direction_map_hole_fill dmhf_checker u_dmhf_checker (.*);
